// ===== hdl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared constants and types of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned LenBits = 64;

  localparam logic [2:0] EvPayload = 3'd0;
  localparam logic [2:0] EvEmpty   = 3'd1;
  localparam logic [2:0] EvClose   = 3'd2;
  localparam logic [2:0] EvPing    = 3'd3;
  localparam logic [2:0] EvPong    = 3'd4;
  localparam logic [2:0] EvUnknown = 3'd5;

  localparam logic [3:0] OpCont   = 4'h0;
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;

  localparam logic [1:0] MsgNone = 2'd0;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [1:0] msg_type;
    logic       last;
  } wsd_result_t;

endpackage

// ===== hdl/websocket_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side WebSocket frame parser: header, length, masking key and
// payload unmasking, with one event word per data byte, empty final data frame or control frame.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Word
// in       sink       in_valid_i/in_ready_o  stream_byte_i
// out      source     out_valid_o/out_ready_i event_kind_o, payload_byte_o,
//                                            message_type_o, last_in_message_o
//
// One byte is taken every cycle while in_ready_o is high; a byte's event
// word is presented once the parser state update loads the result register
// from the input register. Reset clears all parser state and empties both
// registers.
// When the result register is full and not taken, the parser holds and the
// input register fills, after which in_ready_o drops.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [1:0] message_type_o,
  output logic       last_in_message_o
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 out_free;
  logic                 fire;
  logic                 res_valid;
  wsd_pkg::wsd_result_t res;
  wsd_pkg::wsd_result_t res_out;

  assign fire = s1_valid && out_free;

  wsd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .stream_byte_i(stream_byte_i),
    .consume_i    (fire),
    .valid_o      (s1_valid),
    .byte_o       (s1_byte)
  );

  wsd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (s1_byte),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wsd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .res_valid_i(res_valid),
    .res_i      (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign event_kind_o      = res_out.kind;
  assign payload_byte_o    = res_out.data;
  assign message_type_o    = res_out.msg_type;
  assign last_in_message_o = res_out.last;

endmodule

// ===== hdl/wsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register that holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  input  logic       consume_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || consume_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= stream_byte_i;
    end
  end

endmodule

// ===== hdl/wsd_core.sv =====
// ----------------------------------------------------------------------------
// wsd_core
// Frame header parser, length tracking and payload unmasking.
// ----------------------------------------------------------------------------
module wsd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output wsd_pkg::wsd_result_t res_o
);

  typedef enum logic [2:0] {
    PhHdr0   = 3'd0,
    PhHdr1   = 3'd1,
    PhExt    = 3'd2,
    PhKey    = 3'd3,
    PhData   = 3'd4,
    PhClosed = 3'd5
  } phase_e;

  localparam logic [wsd_pkg::LenBits-1:0] LenMax = '1;

  phase_e                       phase_q, phase_d;
  logic                         fin_q, fin_d;
  logic [3:0]                   op_q, op_d;
  logic                         masked_q, masked_d;
  logic [3:0]                   ext_left_q, ext_left_d;
  logic [wsd_pkg::LenBits-1:0]  len_q, len_d;
  logic                         ovf_q, ovf_d;
  logic [31:0]                  key_q, key_d;
  logic [1:0]                   midx_q, midx_d;
  logic [1:0]                   frag_op_q, frag_op_d;

  logic                         hdr_done;
  logic                         ctrl_event;
  logic                         is_data;
  logic [7:0]                   key_byte;
  logic [1:0]                   data_type;

  assign is_data   = (op_q == wsd_pkg::OpCont) || (op_q == wsd_pkg::OpText) ||
                     (op_q == wsd_pkg::OpBinary);
  assign key_byte  = key_q[{~midx_q, 3'b000} +: 8];
  assign data_type = (op_q == wsd_pkg::OpCont) ? frag_op_q : op_q[1:0];

  always_comb begin
    phase_d     = phase_q;
    fin_d       = fin_q;
    op_d        = op_q;
    masked_d    = masked_q;
    ext_left_d  = ext_left_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    key_d       = key_q;
    midx_d      = midx_q;
    frag_op_d   = frag_op_q;
    hdr_done    = 1'b0;
    ctrl_event  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (phase_q)
      PhHdr0: begin
        fin_d   = byte_i[7];
        op_d    = byte_i[3:0];
        phase_d = PhHdr1;
      end
      PhHdr1: begin
        masked_d = byte_i[7];
        key_d    = '0;
        midx_d   = '0;
        len_d    = '0;
        ovf_d    = 1'b0;
        if (byte_i[6:0] == wsd_pkg::Len16Code || byte_i[6:0] == wsd_pkg::Len64Code) begin
          ext_left_d = (byte_i[6:0] == wsd_pkg::Len16Code) ? 4'd2 : 4'd8;
          phase_d    = PhExt;
        end else begin
          len_d = {{(wsd_pkg::LenBits-7){1'b0}}, byte_i[6:0]};
          if (byte_i[7]) begin
            phase_d = PhKey;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PhExt: begin
        len_d      = {len_q[wsd_pkg::LenBits-9:0], byte_i};
        ovf_d      = ovf_q || (len_q[wsd_pkg::LenBits-1 -: 8] != 8'd0);
        ext_left_d = ext_left_q - 4'd1;
        if (ext_left_d == 4'd0) begin
          if (ovf_d) begin
            len_d = LenMax;
          end
          if (masked_q) begin
            phase_d = PhKey;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PhKey: begin
        key_d = {key_q[23:0], byte_i};
        if (midx_q == 2'd3) begin
          hdr_done = 1'b1;
        end else begin
          midx_d = midx_q + 2'd1;
        end
      end
      PhData: begin
        midx_d = midx_q + 2'd1;
        len_d  = len_q - {{(wsd_pkg::LenBits-1){1'b0}}, 1'b1};
        if (!is_data) begin
          if (len_d == '0) begin
            ctrl_event = 1'b1;
          end
        end else begin
          res_valid_o    = 1'b1;
          res_o.kind     = wsd_pkg::EvPayload;
          res_o.data     = masked_q ? (byte_i ^ key_byte) : byte_i;
          res_o.msg_type = data_type;
          res_o.last     = fin_q && (len_d == '0);
          if (len_d == '0) begin
            phase_d = PhHdr0;
          end
        end
      end
      PhClosed: begin
      end
      default: begin
        phase_d = PhHdr0;
      end
    endcase

    if (hdr_done) begin
      midx_d = '0;
      if ((op_q == wsd_pkg::OpText || op_q == wsd_pkg::OpBinary) && !fin_q) begin
        frag_op_d = op_q[1:0];
      end
      if (len_d != '0) begin
        phase_d = PhData;
      end else if (!is_data) begin
        ctrl_event = 1'b1;
      end else begin
        phase_d = PhHdr0;
        if (fin_q) begin
          res_valid_o    = 1'b1;
          res_o.kind     = wsd_pkg::EvEmpty;
          res_o.msg_type = data_type;
          res_o.last     = 1'b1;
        end
      end
    end

    if (ctrl_event) begin
      res_valid_o = 1'b1;
      res_o       = '0;
      phase_d     = PhHdr0;
      case (op_q)
        wsd_pkg::OpClose: begin
          res_o.kind = wsd_pkg::EvClose;
          phase_d    = PhClosed;
        end
        wsd_pkg::OpPing: res_o.kind = wsd_pkg::EvPing;
        wsd_pkg::OpPong: res_o.kind = wsd_pkg::EvPong;
        default:         res_o.kind = wsd_pkg::EvUnknown;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHdr0;
      fin_q      <= 1'b0;
      op_q       <= '0;
      masked_q   <= 1'b0;
      ext_left_q <= '0;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      key_q      <= '0;
      midx_q     <= '0;
      frag_op_q  <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      fin_q      <= fin_d;
      op_q       <= op_d;
      masked_q   <= masked_d;
      ext_left_q <= ext_left_d;
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      key_q      <= key_d;
      midx_q     <= midx_d;
      frag_op_q  <= frag_op_d;
    end
  end

endmodule

// ===== hdl/wsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register that holds one event until the sink takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 res_valid_i,
  input  wsd_pkg::wsd_result_t res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wsd_pkg::wsd_result_t res_o
);

  logic                 valid_q;
  wsd_pkg::wsd_result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule
